/* rtl/core/bcc_pkg.sv */
package bcc_pkg;

  localparam int NUM_BUTTONS_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;
  localparam int FLAG_W          = 16;
  localparam int STAMP_W         = 32;
  localparam int CFG_W           = 32;
  localparam int CFG_AW          = 3;

  typedef enum logic {
    REG_MIN_GAP = 1'b0,
    REG_MAX_GAP = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_gap;
    logic [CFG_W-1:0] max_gap;
  } gap_cfg_t;

  typedef struct packed {
    logic click;
    logic long_click;
    logic dbl;
  } lane_flags_t;

endpackage

/* rtl/core/bcc_cfg.sv */
module bcc_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [bcc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [bcc_pkg::CFG_W-1:0]  cfg_pwdata,
  output logic [bcc_pkg::CFG_W-1:0]  cfg_prdata,
  output logic                      cfg_pready,
  output bcc_pkg::gap_cfg_t         gap_cfg
);
  import bcc_pkg::*;

  logic [CFG_W-1:0] min_gap_r, min_gap_nxt;
  logic [CFG_W-1:0] max_gap_r, max_gap_nxt;
  logic             wr_en;
  reg_idx_t         idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  // word address; low byte-offset bits are ignored
  assign idx        = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    min_gap_nxt = min_gap_r;
    max_gap_nxt = max_gap_r;
    if (wr_en) begin
      case (idx)
        REG_MIN_GAP: min_gap_nxt = cfg_pwdata;
        REG_MAX_GAP: max_gap_nxt = cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_GAP: cfg_prdata = min_gap_r;
      REG_MAX_GAP: cfg_prdata = max_gap_r;
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r <= '0;
      max_gap_r <= '0;
    end else begin
      min_gap_r <= min_gap_nxt;
      max_gap_r <= max_gap_nxt;
    end
  end

  assign gap_cfg.min_gap = min_gap_r;
  assign gap_cfg.max_gap = max_gap_r;

endmodule

/* rtl/core/bcc_lane.sv */
module bcc_lane #(
  parameter int TimeBits = bcc_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                level,
  input  logic [TimeBits-1:0] now,
  input  bcc_pkg::gap_cfg_t   gap_cfg,
  output bcc_pkg::lane_flags_t flags
);
  import bcc_pkg::*;

  localparam int CmpW = (TimeBits > CFG_W) ? TimeBits : CFG_W;

  logic                prev_r, prev_nxt;
  logic                pend_r, pend_nxt;
  logic                long_r, long_nxt;
  logic                dbl_r, dbl_nxt;
  logic [TimeBits-1:0] stamp_r, stamp_nxt;

  logic [TimeBits-1:0] gap;
  logic [CmpW-1:0]     gap_ext, min_ext, max_ext;
  logic                rise, qual, restart, click;

  assign gap     = now - stamp_r;
  assign gap_ext = CmpW'(gap);
  assign min_ext = CmpW'(gap_cfg.min_gap);
  assign max_ext = CmpW'(gap_cfg.max_gap);
  assign rise    = level & ~prev_r;
  assign qual    = pend_r && (min_ext < gap_ext) && (gap_ext < max_ext);
  // a restarted press has zero age, so it cannot fire a click this sample
  assign restart = rise & ~qual;

  always_comb begin
    pend_nxt  = pend_r;
    long_nxt  = long_r;
    dbl_nxt   = dbl_r;
    stamp_nxt = stamp_r;
    click     = 1'b0;
    if (level) begin
      if (rise) begin
        if (qual) begin
          dbl_nxt  = 1'b1;
          pend_nxt = 1'b0;
        end else begin
          dbl_nxt   = 1'b0;
          stamp_nxt = now;
          pend_nxt  = 1'b1;
        end
      end
    end else begin
      if (prev_r) long_nxt = 1'b0;
      dbl_nxt = 1'b0;
    end
    if (pend_nxt && !restart && (gap_ext > max_ext)) begin
      click    = 1'b1;
      long_nxt = level;
      pend_nxt = 1'b0;
    end
    prev_nxt = level;
  end

  assign flags.click      = click;
  assign flags.long_click = long_nxt;
  assign flags.dbl        = dbl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      pend_r <= 1'b0;
      long_r <= 1'b0;
      dbl_r  <= 1'b0;
    end else if (en) begin
      prev_r <= prev_nxt;
      pend_r <= pend_nxt;
      long_r <= long_nxt;
      dbl_r  <= dbl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) stamp_r <= stamp_nxt;
  end

`ifndef SYNTHESIS
  a_click_excl_dbl: assert property (@(posedge clk) disable iff (!rst_n)
    en |-> !(flags.click && flags.dbl))
    else $error("click and double click in the same sample");
  a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
    long_r |-> prev_r)
    else $error("long click active on a released button");
  a_dbl_state: assert property (@(posedge clk) disable iff (!rst_n)
    dbl_r |-> (prev_r && !pend_r))
    else $error("double click with released button or pending press");
`endif

endmodule

/* rtl/core/bcc_merge.sv */
module bcc_merge #(
  parameter int NumButtons = bcc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  bcc_pkg::lane_flags_t        lane_flags [NumButtons],
  output logic                        busy,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [3*bcc_pkg::FLAG_W-1:0] out_tdata
);
  import bcc_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [FLAG_W-1:0]    click_v, long_v, dbl_v;
  logic [3*FLAG_W-1:0]  data_r;

  for (genvar i = 0; i < FLAG_W; i++) begin : g_pack
    if (i < NumButtons) begin : g_lane
      assign click_v[i] = lane_flags[i].click;
      assign long_v[i]  = lane_flags[i].long_click;
      assign dbl_v[i]   = lane_flags[i].dbl;
    end else begin : g_none
      assign click_v[i] = 1'b0;
      assign long_v[i]  = 1'b0;
      assign dbl_v[i]   = 1'b0;
    end
  end

  // stays free to load while the held transaction is being taken
  assign busy = valid_r & ~out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_tready) valid_nxt = 1'b0;
    if (load)       valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= {dbl_v, long_v, click_v};
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

/* rtl/core/button_click_classifier.sv */
// Latency: an accepted sample's result shows on out_* from the next cycle.
// Throughput: one sample per cycle while in_tready is high; every button has its
// own lane with one subtract and three compares, and the merge register holds the
// packed flags. in_tready drops only while a result waits and out_tready is low.
// Reset (rst_n low, synchronous): all button state but the press time stamps, both
// gap registers and the output valid are cleared.
module button_click_classifier #(
  parameter int NumButtons = bcc_pkg::NUM_BUTTONS_DEF,
  parameter int TimeBits   = bcc_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [15:0] button_bits, [47:16] now_time
  input  logic [bcc_pkg::FLAG_W+bcc_pkg::STAMP_W-1:0] in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [15:0] click_flags, [31:16] long_click_flags, [47:32] double_click_flags
  output logic [3*bcc_pkg::FLAG_W-1:0] out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [bcc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [bcc_pkg::CFG_W-1:0]    cfg_pwdata,
  output logic [bcc_pkg::CFG_W-1:0]    cfg_prdata,
  output logic                         cfg_pready
);
  import bcc_pkg::*;

  localparam int WideW = (TimeBits > STAMP_W) ? TimeBits : STAMP_W;

  gap_cfg_t          gap_cfg;
  lane_flags_t       lane_flags [NumButtons];
  logic              accept, busy;
  logic [FLAG_W-1:0] buttons;
  logic [WideW-1:0]  now_wide;
  logic [TimeBits-1:0] now;

  assign buttons  = in_tdata[FLAG_W-1:0];
  assign now_wide = WideW'(in_tdata[FLAG_W +: STAMP_W]);
  assign now      = now_wide[TimeBits-1:0];

  assign in_tready = ~busy;
  assign accept    = in_tvalid & in_tready;

  bcc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .gap_cfg     (gap_cfg)
  );

  for (genvar i = 0; i < NumButtons; i++) begin : g_lane
    logic level;
    // buttons past the sample width always read as released
    if (i < FLAG_W) begin : g_in
      assign level = buttons[i];
    end else begin : g_off
      assign level = 1'b0;
    end

    bcc_lane #(
      .TimeBits (TimeBits)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (accept),
      .level   (level),
      .now     (now),
      .gap_cfg (gap_cfg),
      .flags   (lane_flags[i])
    );
  end

  bcc_merge #(
    .NumButtons (NumButtons)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .lane_flags (lane_flags),
    .busy       (busy),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
